[hw/rtl/ccc_pkg.sv]
// Character class counter: shared constants, types and helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ccc_pkg;

  localparam int NUM_CATS = 8;
  localparam int SPEC_LEN = 32;

  localparam int CAT_W   = (NUM_CATS > 1) ? $clog2(NUM_CATS) : 1;
  localparam int TOT_W   = $clog2(NUM_CATS + 1);
  localparam int LEN_W   = $clog2(SPEC_LEN + 1);
  localparam int ADDR_W  = $clog2(SPEC_LEN);
  localparam int CNT_W   = $clog2(SPEC_LEN + 2);
  localparam int COUNT_W = 16;

  localparam logic [7:0]         CH_CARET  = 8'h5E;
  localparam logic [7:0]         CH_DASH   = 8'h2D;
  localparam logic [8:0]         CASE_GAP  = 9'd32;
  localparam logic [7:0]         CH_UP_A   = 8'h41;
  localparam logic [7:0]         CH_UP_Z   = 8'h5A;
  localparam logic [7:0]         CH_LO_A   = 8'h61;
  localparam logic [7:0]         CH_LO_Z   = 8'h7A;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_NEW_CAT = 2'd0,
    OP_APPEND  = 2'd1,
    OP_TEXT    = 2'd2,
    OP_EOL     = 2'd3
  } ccc_op_e;

  typedef logic [NUM_CATS-1:0][7:0]       ccc_row_t;
  typedef logic [NUM_CATS-1:0][LEN_W-1:0] ccc_lens_t;

  // walk control from the sequencer to the match lanes
  typedef struct packed {
    logic             clear;
    logic             shift;
    logic             eval;
    logic [LEN_W-1:0] pos;
  } ccc_step_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

endpackage

[hw/rtl/ccc_spec_mem.sv]
// Spec store: one row per spec position, one byte lane per category.
// Byte-lane write, registered read. Depends on ccc_pkg.
`timescale 1ns / 1ps

module ccc_spec_mem
  import ccc_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [CAT_W-1:0]  wlane_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output ccc_row_t          rdata_o
);

  ccc_row_t mem [SPEC_LEN];
  ccc_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i][wlane_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ccc_match.sv]
// Match lanes: one per category, each walks its spec one position per step
// with a three-byte window. Depends on ccc_pkg.
`timescale 1ns / 1ps

module ccc_match
  import ccc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccc_step_t           step_i,
  input  logic [7:0]          char_i,
  input  ccc_lens_t           lens_i,
  input  ccc_row_t            next_i,
  output logic [NUM_CATS-1:0] hit_o
);

  ccc_row_t            cur_q, prev_q;
  logic [NUM_CATS-1:0] seen_q, hit_q;
  logic [NUM_CATS-1:0] seen_d, hit_d;
  logic                letter;
  logic [8:0]          c9;

  assign letter = is_letter(char_i);
  assign c9     = {1'b0, char_i};

  always_comb begin
    logic             in_spec, interior, caret_here, dash_here, eq_case, m;
    logic [LEN_W:0]   pos_nx;
    logic [8:0]       t9;
    seen_d = seen_q;
    hit_d  = hit_q;
    pos_nx = {1'b0, step_i.pos} + (LEN_W+1)'(1);
    for (int i = 0; i < NUM_CATS; i++) begin
      in_spec    = step_i.pos < lens_i[i];
      interior   = (step_i.pos != '0) && (pos_nx < {1'b0, lens_i[i]});
      caret_here = (cur_q[i] == CH_CARET) && letter;
      dash_here  = (cur_q[i] == CH_DASH) && interior;
      t9         = {1'b0, cur_q[i]};
      eq_case    = (c9 == t9) || ((c9 + CASE_GAP) == t9) || (c9 == (t9 + CASE_GAP));
      m = 1'b0;
      if (seen_q[i] && letter && eq_case) begin
        m = 1'b1;
      end
      if (dash_here) begin
        if ((char_i >= prev_q[i]) && (char_i < next_i[i])) begin
          m = 1'b1;
        end
      end else if (!caret_here && (char_i == cur_q[i])) begin
        m = 1'b1;
      end
      if (step_i.eval && in_spec) begin
        hit_d[i]  = hit_q[i] | m;
        seen_d[i] = seen_q[i] | (cur_q[i] == CH_CARET);
      end
    end
    if (step_i.clear) begin
      seen_d = '0;
      hit_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      hit_q  <= '0;
    end else begin
      seen_q <= seen_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.shift) begin
      prev_q <= cur_q;
      cur_q  <= next_i;
    end
  end

  assign hit_o = hit_q;

endmodule

[hw/rtl/char_class_counter_top.sv]
// Character class counter top level: stream ports, sequencer, line counts.
// Depends on ccc_pkg, ccc_spec_mem and ccc_match.
`timescale 1ns / 1ps

// Category opens and spec appends are handled in the idle state, as is an end
// of line with no category open. A text character walks the spec store one row
// per cycle, all categories in parallel, up to the longest spec loaded since
// reset, then updates the counts; with no spec byte loaded it goes straight to
// the count update. End of line emits one word per open category, one per cycle
// while the sink is ready; the next input word is taken once the last of them
// sits in the output register.
module char_class_counter_top
  import ccc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] count
  output logic [2:0]  m_axis_tuser_o,   // [2:0] category
  output logic        m_axis_tlast_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_UPDATE,
    S_REPORT
  } state_e;

  state_e                              state_q;
  logic [TOT_W-1:0]                    total_q;
  ccc_lens_t                           lens_q;
  logic [LEN_W-1:0]                    max_len_q;
  logic [NUM_CATS-1:0][COUNT_W-1:0]    counts_q;
  logic [CNT_W-1:0]                    cnt_q;
  logic [7:0]                          char_q;
  logic [CAT_W-1:0]                    rep_idx_q;
  logic                                m_valid_q, m_last_q;
  logic [2:0]                          m_cat_q;
  logic [COUNT_W-1:0]                  m_count_q;

  logic                accept;
  ccc_op_e             op;
  logic [CAT_W-1:0]    cur_cat;
  logic                mem_we;
  ccc_row_t            rdata;
  ccc_step_t           step;
  logic [NUM_CATS-1:0] hit;
  logic                out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign op              = ccc_op_e'(s_axis_tuser_i);
  assign cur_cat         = CAT_W'(total_q - TOT_W'(1));
  assign mem_we          = accept && (op == OP_APPEND) && (total_q != '0)
                           && (lens_q[cur_cat] < LEN_W'(SPEC_LEN));
  assign out_free        = !m_valid_q || m_axis_tready_i;

  always_comb begin
    step.clear = accept && (op == OP_TEXT);
    step.shift = (state_q == S_WALK) && (cnt_q != '0);
    step.eval  = (state_q == S_WALK) && (cnt_q >= CNT_W'(2));
    step.pos   = LEN_W'(cnt_q - CNT_W'(2));
  end

  ccc_spec_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (lens_q[cur_cat][ADDR_W-1:0]),
    .wlane_i (cur_cat),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (cnt_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  ccc_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (char_q),
    .lens_i (lens_q),
    .next_i (rdata),
    .hit_o  (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      lens_q    <= '0;
      max_len_q <= '0;
      counts_q  <= '0;
      cnt_q     <= '0;
      char_q    <= '0;
      rep_idx_q <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      m_cat_q   <= '0;
      m_count_q <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i && (state_q != S_REPORT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_NEW_CAT: begin
                if (total_q < TOT_W'(NUM_CATS)) begin
                  lens_q[CAT_W'(total_q)] <= '0;
                  total_q                 <= total_q + TOT_W'(1);
                end
              end
              OP_APPEND: begin
                if (mem_we) begin
                  lens_q[cur_cat] <= lens_q[cur_cat] + LEN_W'(1);
                  if (lens_q[cur_cat] >= max_len_q) begin
                    max_len_q <= lens_q[cur_cat] + LEN_W'(1);
                  end
                end
              end
              OP_TEXT: begin
                char_q <= s_axis_tdata_i;
                cnt_q  <= '0;
                state_q <= (max_len_q == '0) ? S_UPDATE : S_WALK;
              end
              default: begin
                rep_idx_q <= '0;
                if (total_q != '0) begin
                  state_q <= S_REPORT;
                end
              end
            endcase
          end
        end
        S_WALK: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(max_len_q) + CNT_W'(1)) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          for (int i = 0; i < NUM_CATS; i++) begin
            if (hit[i] && (counts_q[i] != COUNT_MAX)) begin
              counts_q[i] <= counts_q[i] + COUNT_W'(1);
            end
          end
          state_q <= S_IDLE;
        end
        S_REPORT: begin
          if (out_free) begin
            m_valid_q           <= 1'b1;
            m_cat_q             <= 3'(rep_idx_q);
            m_count_q           <= counts_q[rep_idx_q];
            counts_q[rep_idx_q] <= '0;
            rep_idx_q           <= rep_idx_q + CAT_W'(1);
            if (TOT_W'(rep_idx_q) == total_q - TOT_W'(1)) begin
              m_last_q <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              m_last_q <= 1'b0;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_count_q;
  assign m_axis_tuser_o  = m_cat_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

[hw/rtl/ccc_checker.sv]
// Port-level checks for the character class counter, bound to the top level.
// Depends on ccc_pkg and char_class_counter_top.
`timescale 1ns / 1ps

module ccc_checker
  import ccc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  a_report_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o) + 3'd1))
    else $error("report words not back to back in category order");

  a_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == OP_TEXT) |=>
      !s_axis_tready_o)
    else $error("text word did not start a spec walk");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind char_class_counter_top ccc_checker u_ccc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
